@@ hw/rtl/mad_pkg.sv @@
// ----------------------------------------------------------------------------
// mad_pkg
// Shared types and constants of the motion adaptive deinterlacer pixel block.
// ----------------------------------------------------------------------------
package mad_pkg;

    localparam int SAMPLE_BITS = 16;

    // filter coefficients, all fractions of 2**FSHIFT
    localparam int COEF_W = 13;
    localparam logic [COEF_W-1:0] LF0 = 13'd4309;
    localparam logic [COEF_W-1:0] LF1 = 13'd213;
    localparam logic [COEF_W-1:0] HF0 = 13'd5570;
    localparam logic [COEF_W-1:0] HF1 = 13'd3801;
    localparam logic [COEF_W-1:0] HF2 = 13'd1016;
    localparam logic [COEF_W-1:0] SP0 = 13'd5077;
    localparam logic [COEF_W-1:0] SP1 = 13'd981;
    localparam int FSHIFT = 13;

    // datapath widths
    localparam int SW     = SAMPLE_BITS;
    localparam int SUM_W  = SW + 1;
    localparam int SUM2_W = SW + 2;
    localparam int DIF_W  = SW + 3;
    localparam int PROD_W = SUM2_W + COEF_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int CLP_W  = (DIF_W > 17) ? DIF_W : 17;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CEILING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARITY        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_CHECK = 2'd2;

    // kind codes
    localparam logic [1:0] KIND_INTRA = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_EDGE  = 2'd2;

    // frame slots inside a packed row word
    localparam logic [1:0] FRAME_PREV = 2'd0;
    localparam logic [1:0] FRAME_CUR  = 2'd1;
    localparam logic [1:0] FRAME_NEXT = 2'd2;

    typedef struct packed {
        logic [15:0] out_ceiling;
        logic        parity;
        logic        spatial_check;
    } mad_cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] row_minus4;
        logic [47:0] row_minus2;
        logic [47:0] row_center;
        logic [47:0] row_plus2;
        logic [47:0] row_plus4;
        logic [47:0] row_minus1;
        logic [47:0] row_plus1;
        logic [31:0] row_three_away;
        logic        end_of_line;
    } mad_in_t;

    typedef struct packed {
        logic [15:0] pixel_out;
        logic        line_done;
    } mad_out_t;

endpackage

@@ hw/rtl/motion_adaptive_deinterlace_pixel.sv @@
// ----------------------------------------------------------------------------
// motion_adaptive_deinterlace_pixel
// Three-field motion adaptive interpolation of one missing-line pixel.
//
// Input beats carry a vertical window of previous/current/next frame samples
// on in_data, qualified by in_valid; the block holds in_stall high when it
// cannot take a beat. Results leave on out_data with out_valid; the receiver
// holds out_stall high to keep a result in place.
// Five register stages: unpack and absolute differences, motion measure and
// constant multiplies, bound search and filter sums, final shifts and mode
// select, bound and clip into the output register. One pixel is taken every
// cycle in which in_stall is low.
// A stall at the output freezes the stages holding data; empty stages keep
// filling, so in_stall rises only when the whole pipe is full.
// Reset empties the pipe and sets out_ceiling 255, parity 0, spatial_check 1.
// Configuration writes through cfg_write/cfg_index/cfg_data take effect at
// the next edge and are meant for an idle block.
// ----------------------------------------------------------------------------
module motion_adaptive_deinterlace_pixel
    import mad_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mad_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mad_out_t             out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    function automatic logic [SW-1:0] pick(input logic [47:0] row, input logic [1:0] fr);
        logic [15:0] s;
        case (fr)
            FRAME_PREV: s = row[15:0];
            FRAME_CUR:  s = row[31:16];
            FRAME_NEXT: s = row[47:32];
            default:    s = row[47:32];
        endcase
        return s[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] absdiff(input logic [SW-1:0] a, input logic [SW-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic signed [DIF_W-1:0] smax(input logic signed [DIF_W-1:0] a,
                                                     input logic signed [DIF_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [DIF_W-1:0] smin(input logic signed [DIF_W-1:0] a,
                                                     input logic signed [DIF_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    mad_cfg_t cfg;

    mad_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------ control
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || !out_stall;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------ stage 1
    logic [1:0]      fp, fn;
    logic [SW-1:0]   c_next, e_next, p0_next, n0_next;
    logic [SUM_W-1:0] t3_next, m2_next, p2_next, m4_next, p4_next, pn_next, ce_next;
    logic [SUM2_W-1:0] mp2_next, mp4_next;
    logic [SW-1:0]   d_next, td0_next, td1_next, td2_next, cead_next;
    logic [SUM_W-1:0] a1_sum, a2_sum;

    always_comb
    begin
        fp       = cfg.parity ? FRAME_PREV : FRAME_CUR;
        fn       = cfg.parity ? FRAME_CUR : FRAME_NEXT;
        c_next   = pick(in_data.row_minus1, FRAME_CUR);
        e_next   = pick(in_data.row_plus1, FRAME_CUR);
        p0_next  = pick(in_data.row_center, fp);
        n0_next  = pick(in_data.row_center, fn);
        t3_next  = SUM_W'(in_data.row_three_away[SW-1:0])
                 + SUM_W'(in_data.row_three_away[16 +: SW]);
        m2_next  = SUM_W'(pick(in_data.row_minus2, fp)) + SUM_W'(pick(in_data.row_minus2, fn));
        p2_next  = SUM_W'(pick(in_data.row_plus2, fp)) + SUM_W'(pick(in_data.row_plus2, fn));
        m4_next  = SUM_W'(pick(in_data.row_minus4, fp)) + SUM_W'(pick(in_data.row_minus4, fn));
        p4_next  = SUM_W'(pick(in_data.row_plus4, fp)) + SUM_W'(pick(in_data.row_plus4, fn));
        mp2_next = SUM2_W'(m2_next) + SUM2_W'(p2_next);
        mp4_next = SUM2_W'(m4_next) + SUM2_W'(p4_next);
        pn_next  = SUM_W'(p0_next) + SUM_W'(n0_next);
        ce_next  = SUM_W'(c_next) + SUM_W'(e_next);
        d_next   = pn_next[SUM_W-1:1];
        td0_next = absdiff(p0_next, n0_next);
        a1_sum   = SUM_W'(absdiff(pick(in_data.row_minus1, FRAME_PREV), c_next))
                 + SUM_W'(absdiff(pick(in_data.row_plus1, FRAME_PREV), e_next));
        a2_sum   = SUM_W'(absdiff(pick(in_data.row_minus1, FRAME_NEXT), c_next))
                 + SUM_W'(absdiff(pick(in_data.row_plus1, FRAME_NEXT), e_next));
        td1_next = a1_sum[SUM_W-1:1];
        td2_next = a2_sum[SUM_W-1:1];
        cead_next = absdiff(c_next, e_next);
    end

    logic [SW-1:0]     s1_c_reg, s1_e_reg, s1_d_reg, s1_td0_reg, s1_td1_reg, s1_td2_reg;
    logic [SW-1:0]     s1_cead_reg;
    logic [SUM_W-1:0]  s1_t3_reg, s1_m2_reg, s1_p2_reg, s1_pn_reg, s1_ce_reg;
    logic [SUM2_W-1:0] s1_mp2_reg, s1_mp4_reg;
    logic              s1_intra_reg, s1_line_reg, s1_eol_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_c_reg     <= c_next;
            s1_e_reg     <= e_next;
            s1_d_reg     <= d_next;
            s1_td0_reg   <= td0_next;
            s1_td1_reg   <= td1_next;
            s1_td2_reg   <= td2_next;
            s1_cead_reg  <= cead_next;
            s1_t3_reg    <= t3_next;
            s1_m2_reg    <= m2_next;
            s1_p2_reg    <= p2_next;
            s1_pn_reg    <= pn_next;
            s1_ce_reg    <= ce_next;
            s1_mp2_reg   <= mp2_next;
            s1_mp4_reg   <= mp4_next;
            s1_intra_reg <= (in_data.kind == KIND_INTRA);
            s1_line_reg  <= (in_data.kind == KIND_LINE);
            s1_eol_reg   <= in_data.end_of_line;
        end
    end

    // ------------------------------------------------------------------ stage 2
    logic [SW-1:0]           diff_next;
    logic signed [DIF_W-1:0] b_next, f_next, dc_next, de_next;
    logic [PROD_W-1:0]       sp0_next, sp1_next, hf0_next, hf1_next, hf2_next;
    logic [PROD_W-1:0]       lf0_next, lf1_next;

    always_comb
    begin
        diff_next = s1_td0_reg >> 1;
        if (s1_td1_reg > diff_next) diff_next = s1_td1_reg;
        if (s1_td2_reg > diff_next) diff_next = s1_td2_reg;
        b_next  = $signed(DIF_W'(s1_m2_reg >> 1)) - $signed(DIF_W'(s1_c_reg));
        f_next  = $signed(DIF_W'(s1_p2_reg >> 1)) - $signed(DIF_W'(s1_e_reg));
        dc_next = $signed(DIF_W'(s1_d_reg)) - $signed(DIF_W'(s1_c_reg));
        de_next = $signed(DIF_W'(s1_d_reg)) - $signed(DIF_W'(s1_e_reg));
        sp0_next = PROD_W'(s1_ce_reg) * PROD_W'(SP0);
        sp1_next = PROD_W'(s1_t3_reg) * PROD_W'(SP1);
        hf0_next = PROD_W'(s1_pn_reg) * PROD_W'(HF0);
        hf1_next = PROD_W'(s1_mp2_reg) * PROD_W'(HF1);
        hf2_next = PROD_W'(s1_mp4_reg) * PROD_W'(HF2);
        lf0_next = PROD_W'(s1_ce_reg) * PROD_W'(LF0);
        lf1_next = PROD_W'(s1_t3_reg) * PROD_W'(LF1);
    end

    logic [SW-1:0]           s2_diff_reg, s2_d_reg, s2_half_reg;
    logic                    s2_zero_reg, s2_cegt_reg;
    logic signed [DIF_W-1:0] s2_b_reg, s2_f_reg, s2_dc_reg, s2_de_reg;
    logic [PROD_W-1:0]       s2_sp0_reg, s2_sp1_reg, s2_hf0_reg, s2_hf1_reg, s2_hf2_reg;
    logic [PROD_W-1:0]       s2_lf0_reg, s2_lf1_reg;
    logic                    s2_intra_reg, s2_line_reg, s2_eol_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_diff_reg  <= diff_next;
            s2_zero_reg  <= (diff_next == '0);
            s2_cegt_reg  <= (s1_cead_reg > s1_td0_reg);
            s2_d_reg     <= s1_d_reg;
            s2_half_reg  <= s1_ce_reg[SUM_W-1:1];
            s2_b_reg     <= b_next;
            s2_f_reg     <= f_next;
            s2_dc_reg    <= dc_next;
            s2_de_reg    <= de_next;
            s2_sp0_reg   <= sp0_next;
            s2_sp1_reg   <= sp1_next;
            s2_hf0_reg   <= hf0_next;
            s2_hf1_reg   <= hf1_next;
            s2_hf2_reg   <= hf2_next;
            s2_lf0_reg   <= lf0_next;
            s2_lf1_reg   <= lf1_next;
            s2_intra_reg <= s1_intra_reg;
            s2_line_reg  <= s1_line_reg;
            s2_eol_reg   <= s1_eol_reg;
        end
    end

    // ------------------------------------------------------------------ stage 3
    logic signed [DIF_W-1:0] mx, mn, diff3_next;
    logic signed [ACC_W-1:0] sp_next, hf_next;

    always_comb
    begin
        mx = smax(smax(s2_de_reg, s2_dc_reg), smin(s2_b_reg, s2_f_reg));
        mn = smin(smin(s2_de_reg, s2_dc_reg), smax(s2_b_reg, s2_f_reg));
        diff3_next = $signed(DIF_W'(s2_diff_reg));
        if (s2_line_reg || cfg.spatial_check)
            diff3_next = smax(smax(diff3_next, mn), -mx);
        sp_next = $signed(ACC_W'(s2_sp0_reg)) - $signed(ACC_W'(s2_sp1_reg));
        hf_next = $signed(ACC_W'(s2_hf0_reg)) - $signed(ACC_W'(s2_hf1_reg))
                + $signed(ACC_W'(s2_hf2_reg));
    end

    logic signed [DIF_W-1:0] s3_diff_reg;
    logic signed [ACC_W-1:0] s3_sp_reg, s3_hf_reg;
    logic [PROD_W-1:0]       s3_lf0_reg, s3_lf1_reg;
    logic [SW-1:0]           s3_d_reg, s3_half_reg;
    logic                    s3_zero_reg, s3_cegt_reg, s3_intra_reg, s3_line_reg, s3_eol_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_diff_reg  <= diff3_next;
            s3_sp_reg    <= sp_next;
            s3_hf_reg    <= hf_next;
            s3_lf0_reg   <= s2_lf0_reg;
            s3_lf1_reg   <= s2_lf1_reg;
            s3_d_reg     <= s2_d_reg;
            s3_half_reg  <= s2_half_reg;
            s3_zero_reg  <= s2_zero_reg;
            s3_cegt_reg  <= s2_cegt_reg;
            s3_intra_reg <= s2_intra_reg;
            s3_line_reg  <= s2_line_reg;
            s3_eol_reg   <= s2_eol_reg;
        end
    end

    // ------------------------------------------------------------------ stage 4
    logic signed [ACC_W-1:0] lf_sum;
    logic signed [ACC_W-1:0] sp_shift, lf_shift;
    logic signed [DIF_W-1:0] sp_i, line_i, interp_next, upper_next, lower_next, d_s;

    always_comb
    begin
        lf_sum   = (s3_hf_reg >>> 2) + $signed(ACC_W'(s3_lf0_reg)) - $signed(ACC_W'(s3_lf1_reg));
        sp_shift = s3_sp_reg >>> FSHIFT;
        lf_shift = lf_sum >>> FSHIFT;
        sp_i     = sp_shift[DIF_W-1:0];
        line_i   = lf_shift[DIF_W-1:0];
        if (s3_intra_reg)
            interp_next = sp_i;
        else if (s3_line_reg)
            interp_next = s3_cegt_reg ? line_i : sp_i;
        else
            interp_next = $signed(DIF_W'(s3_half_reg));
        d_s        = $signed(DIF_W'(s3_d_reg));
        upper_next = d_s + s3_diff_reg;
        lower_next = d_s - s3_diff_reg;
    end

    logic signed [DIF_W-1:0] s4_interp_reg, s4_upper_reg, s4_lower_reg;
    logic [SW-1:0]           s4_d_reg;
    logic                    s4_zero_reg, s4_intra_reg, s4_eol_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_interp_reg <= interp_next;
            s4_upper_reg  <= upper_next;
            s4_lower_reg  <= lower_next;
            s4_d_reg      <= s3_d_reg;
            s4_zero_reg   <= s3_zero_reg;
            s4_intra_reg  <= s3_intra_reg;
            s4_eol_reg    <= s3_eol_reg;
        end
    end

    // ------------------------------------------------------------------ stage 5
    logic signed [DIF_W-1:0] bounded;
    logic signed [CLP_W-1:0] wide, cmax;
    logic [15:0]             pix_next;
    logic                    raw_next;

    always_comb
    begin
        if (s4_intra_reg)
            bounded = s4_interp_reg;
        else if (s4_interp_reg > s4_upper_reg)
            bounded = s4_upper_reg;
        else if (s4_interp_reg < s4_lower_reg)
            bounded = s4_lower_reg;
        else
            bounded = s4_interp_reg;
        wide = CLP_W'(bounded);
        cmax = $signed(CLP_W'(cfg.out_ceiling));
        // no motion passes the temporal average straight through, unclipped
        raw_next = !s4_intra_reg && s4_zero_reg;
        if (raw_next)
            pix_next = 16'(s4_d_reg);
        else if (wide < 0)
            pix_next = '0;
        else if (wide > cmax)
            pix_next = cfg.out_ceiling;
        else
            pix_next = wide[15:0];
    end

    mad_out_t out_reg;
    logic     o_raw_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            out_reg.pixel_out <= pix_next;
            out_reg.line_done <= s4_eol_reg;
            o_raw_reg         <= raw_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    // back-pressure only originates from a stalled, full pipe
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && out_valid && out_stall))
        else $error("input stalled while pipe has a hole or output moves");

    // clipped results never exceed the limit
    a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !o_raw_reg) |-> (out_data.pixel_out <= cfg.out_ceiling))
        else $error("clipped pixel above out_ceiling");

    // a frozen stage four keeps its beat and its data
    a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && out_valid && out_stall) |=> (v4_reg && $stable(s4_interp_reg)))
        else $error("stage four lost or changed a beat under stall");
`endif

endmodule

@@ hw/rtl/mad_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mad_cfg_regs
// Configuration register bank: clip limit, field parity, spatial check.
// ----------------------------------------------------------------------------
module mad_cfg_regs
    import mad_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output mad_cfg_t             cfg
);

    mad_cfg_t cfg_reg;
    mad_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_OUT_CEILING:   cfg_next.out_ceiling   = cfg_data;
                REG_PARITY:        cfg_next.parity        = cfg_data[0];
                REG_SPATIAL_CHECK: cfg_next.spatial_check = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.out_ceiling   <= 16'd255;
            cfg_reg.parity        <= 1'b0;
            cfg_reg.spatial_check <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ verif/tb_motion_adaptive_deinterlace_pixel.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_motion_adaptive_deinterlace_pixel
// Drives windows of previous/current/next frame samples through the pixel
// interpolator and checks every output pixel against a typed-in value or an
// in-bench predictor. A short directed table is walked first. Random windows
// follow, over several register settings. The sender runs in bursts and the
// receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_motion_adaptive_deinterlace_pixel
    import mad_pkg::*;
();

    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RAND_PER_PHASE = 305;
    localparam int PHASES         = 6;

    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    localparam logic [15:0] SAMPLE_MASK = 16'((1 << SAMPLE_BITS) - 1);

    localparam longint K_LF0 = 4309;
    localparam longint K_LF1 = 213;
    localparam longint K_HF0 = 5570;
    localparam longint K_HF1 = 3801;
    localparam longint K_HF2 = 1016;
    localparam longint K_SP0 = 5077;
    localparam longint K_SP1 = 981;

    typedef struct {
        mad_in_t     beat;
        bit          typed;
        logic [15:0] pixel;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    mad_in_t              in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    mad_out_t             out_data;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_OUT_CEILING;
    logic [15:0]          cfg_data = '0;

    // typed-in expectation travels alongside the beat
    bit          beat_typed = 1'b0;
    logic [15:0] beat_typed_pixel = '0;

    // predictor copy of the registers
    logic [15:0] out_ceiling_q = 16'd255;
    bit          parity_q = 1'b0;
    bit          spatial_check_q = 1'b1;

    mad_out_t pending_pixels[$];
    int       error_count = 0;
    int       pixels_checked = 0;
    int       idle_cycles = 0;
    int       kind_count[4] = '{0, 0, 0, 0};
    int       settings_used = 1;
    int       burst_left = 0;

    logic [1:0] stall_mode = 2'd0;
    int         stall_span = 0;
    logic [2:0] stall_tick = 3'd0;

    motion_adaptive_deinterlace_pixel u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic longint frame_sample(input logic [47:0] row, input logic [1:0] frame);
        logic [15:0] raw;
        raw = row[frame*16 +: 16] & SAMPLE_MASK;
        return longint'({48'd0, raw});
    endfunction

    function automatic longint labs(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint lmax(input longint a, input longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint lmin(input longint a, input longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint clip_pixel(input longint v);
        if (v < 0)
            return 0;
        if (v > longint'({48'd0, out_ceiling_q}))
            return longint'({48'd0, out_ceiling_q});
        return v;
    endfunction

    function automatic longint spatial_tap(input longint c, input longint e, input longint t3);
        return (K_SP0 * (c + e) - K_SP1 * t3) >>> FSHIFT;
    endfunction

    function automatic mad_out_t interpolate_pixel(input mad_in_t px);
        mad_out_t   res;
        logic [1:0] f2p, f2n;
        longint     c, e, t3, p0, n0, avg, td0, td1, td2, motion;
        longint     m2, p2, m4, p4, b, f, dc, de, hi, lo, hf, interp, value;
        f2p = parity_q ? FRAME_PREV : FRAME_CUR;
        f2n = parity_q ? FRAME_CUR : FRAME_NEXT;
        c = frame_sample(px.row_minus1, FRAME_CUR);
        e = frame_sample(px.row_plus1, FRAME_CUR);
        t3 = longint'({48'd0, px.row_three_away[15:0] & SAMPLE_MASK})
           + longint'({48'd0, px.row_three_away[31:16] & SAMPLE_MASK});
        if (px.kind == KIND_INTRA)
        begin
            value = clip_pixel(spatial_tap(c, e, t3));
        end
        else
        begin
            p0 = frame_sample(px.row_center, f2p);
            n0 = frame_sample(px.row_center, f2n);
            avg = (p0 + n0) >>> 1;
            td0 = labs(p0 - n0);
            td1 = (labs(frame_sample(px.row_minus1, FRAME_PREV) - c)
                 + labs(frame_sample(px.row_plus1, FRAME_PREV) - e)) >>> 1;
            td2 = (labs(frame_sample(px.row_minus1, FRAME_NEXT) - c)
                 + labs(frame_sample(px.row_plus1, FRAME_NEXT) - e)) >>> 1;
            motion = lmax(lmax(td0 >>> 1, td1), td2);
            if (motion == 0)
            begin
                // static area: temporal average goes out unclipped
                value = avg;
            end
            else
            begin
                m2 = frame_sample(px.row_minus2, f2p) + frame_sample(px.row_minus2, f2n);
                p2 = frame_sample(px.row_plus2, f2p) + frame_sample(px.row_plus2, f2n);
                if (px.kind == KIND_LINE || spatial_check_q)
                begin
                    b = (m2 >>> 1) - c;
                    f = (p2 >>> 1) - e;
                    dc = avg - c;
                    de = avg - e;
                    hi = lmax(lmax(de, dc), lmin(b, f));
                    lo = lmin(lmin(de, dc), lmax(b, f));
                    motion = lmax(lmax(motion, lo), -hi);
                end
                if (px.kind == KIND_LINE)
                begin
                    if (labs(c - e) > td0)
                    begin
                        m4 = frame_sample(px.row_minus4, f2p) + frame_sample(px.row_minus4, f2n);
                        p4 = frame_sample(px.row_plus4, f2p) + frame_sample(px.row_plus4, f2n);
                        hf = K_HF0 * (p0 + n0) - K_HF1 * (m2 + p2) + K_HF2 * (m4 + p4);
                        interp = ((hf >>> 2) + K_LF0 * (c + e) - K_LF1 * t3) >>> FSHIFT;
                    end
                    else
                    begin
                        interp = spatial_tap(c, e, t3);
                    end
                end
                else
                begin
                    // edge mode, unused kind included
                    interp = (c + e) >>> 1;
                end
                if (interp > avg + motion)
                    interp = avg + motion;
                else if (interp < avg - motion)
                    interp = avg - motion;
                value = clip_pixel(interp);
            end
        end
        res.pixel_out = value[15:0];
        res.line_done = px.end_of_line;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------------
    function automatic mad_in_t frames(input logic [1:0] kind, input logic [15:0] prv,
                                       input logic [15:0] cur, input logic [15:0] nxt,
                                       input logic eol);
        mad_in_t w;
        w.kind = kind;
        w.row_minus4 = {nxt, cur, prv};
        w.row_minus2 = {nxt, cur, prv};
        w.row_center = {nxt, cur, prv};
        w.row_plus2 = {nxt, cur, prv};
        w.row_plus4 = {nxt, cur, prv};
        w.row_minus1 = {nxt, cur, prv};
        w.row_plus1 = {nxt, cur, prv};
        w.row_three_away = {cur, cur};
        w.end_of_line = eol;
        return w;
    endfunction

    function automatic mad_in_t window(input logic [1:0] kind, input logic [15:0] s,
                                       input logic eol);
        return frames(kind, s, s, s, eol);
    endfunction

    function automatic logic [15:0] jitter(input logic [15:0] base, input int spread);
        int v;
        v = int'({16'd0, base}) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    // styles: full random, near-static jitter, values around the clip range,
    // and exactly static rows (no motion)
    function automatic logic [47:0] rand_row(input int style, input logic [15:0] base);
        logic [15:0] s;
        case (style)
            0: return 48'({$urandom(), $urandom()});
            1: return {jitter(base, 6), jitter(base, 6), jitter(base, 6)};
            2: return {16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                       16'($urandom_range(0, 300))};
            default:
            begin
                s = jitter(base, 40);
                return {s, s, s};
            end
        endcase
    endfunction

    function automatic mad_in_t rand_window(input logic [1:0] kind);
        mad_in_t     w;
        int          style;
        logic [15:0] base;
        logic [47:0] far_row;
        style = $urandom_range(0, 3);
        base = 16'($urandom_range(0, 65535));
        w.kind = kind;
        w.row_minus4 = rand_row(style, base);
        w.row_minus2 = rand_row(style, base);
        w.row_center = rand_row(style, base);
        w.row_plus2 = rand_row(style, base);
        w.row_plus4 = rand_row(style, base);
        w.row_minus1 = rand_row(style, base);
        w.row_plus1 = rand_row(style, base);
        far_row = rand_row(style, base);
        w.row_three_away = far_row[31:0];
        w.end_of_line = ($urandom_range(0, 15) == 0);
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------
    task automatic send_beat(input mad_in_t beat, input bit typed, input logic [15:0] px);
        in_valid <= 1'b1;
        in_data <= beat;
        beat_typed <= typed;
        beat_typed_pixel <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_pixels.size() != 0);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] clip, input bit par, input bit sc);
        cfg_write <= 1'b1;
        cfg_index <= REG_OUT_CEILING;
        cfg_data <= clip;
        @(posedge clk);
        cfg_index <= REG_PARITY;
        cfg_data <= {15'd0, par};
        @(posedge clk);
        cfg_index <= REG_SPATIAL_CHECK;
        cfg_data <= {15'd0, sc};
        @(posedge clk);
        cfg_write <= 1'b0;
        out_ceiling_q = clip;
        parity_q = par;
        spatial_check_q = sc;
        settings_used++;
    endtask

    // receiver stall pattern: quiet, light random, heavy random, periodic
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            stall_tick <= stall_tick + 3'd1;
            if (stall_span == 0)
            begin
                stall_mode <= 2'($urandom_range(0, 3));
                stall_span <= $urandom_range(20, 200);
            end
            else
            begin
                stall_span <= stall_span - 1;
            end
            case (stall_mode)
                2'd0:    out_stall <= 1'b0;
                2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
                2'd2:    out_stall <= ($urandom_range(0, 7) != 0);
                default: out_stall <= stall_tick[2];
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // beat monitor and checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : beat_monitor
        mad_out_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (beat_typed)
                    pending_pixels.push_back(mad_out_t'{beat_typed_pixel, in_data.end_of_line});
                else
                    pending_pixels.push_back(interpolate_pixel(in_data));
                kind_count[in_data.kind]++;
            end
            if (out_valid && !out_stall)
            begin
                pixels_checked++;
                if (pending_pixels.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected output beat: pixel_out=%h line_done=%b",
                                 out_data.pixel_out, out_data.line_done);
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (out_data.pixel_out !== want.pixel_out ||
                        out_data.line_done !== want.line_done)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("pixel %0d: expected %h/%b, got %h/%b (pixel_out/line_done)",
                                     pixels_checked, want.pixel_out, want.line_done,
                                     out_data.pixel_out, out_data.line_done);
                    end
                end
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t   directed_rows[$];
        mad_in_t     w;
        logic [15:0] clip;
        bit          par, sc;
        int          phase;
        burst_left = $urandom_range(1, 20);

        // reset settings: out_ceiling 255, parity 0, spatial check on
        directed_rows.push_back(stim_row_t'{window(KIND_INTRA, 16'h0000, 1'b0), 1'b1, 16'h0000});
        directed_rows.push_back(stim_row_t'{window(KIND_INTRA, 16'hFFFF, 1'b1), 1'b1, 16'd255});
        w = window(KIND_INTRA, 16'h0000, 1'b0);
        w.row_three_away = '1;
        directed_rows.push_back(stim_row_t'{w, 1'b1, 16'h0000});
        directed_rows.push_back(stim_row_t'{window(KIND_LINE, 16'h0000, 1'b0), 1'b1, 16'h0000});
        // no motion passes the average through above out_ceiling
        directed_rows.push_back(stim_row_t'{window(KIND_LINE, 16'h1234, 1'b0), 1'b1, 16'h1234});
        directed_rows.push_back(stim_row_t'{window(KIND_EDGE, 16'hFFFF, 1'b1), 1'b1, 16'hFFFF});
        directed_rows.push_back(stim_row_t'{window(KIND_UNUSED, 16'h00FF, 1'b0), 1'b1, 16'h00FF});
        directed_rows.push_back(stim_row_t'{frames(KIND_LINE, 16'h0000, 16'hFFFF, 16'h0000, 1'b0),
                                            1'b0, 16'h0000});
        directed_rows.push_back(stim_row_t'{frames(KIND_LINE, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1),
                                            1'b0, 16'h0000});
        directed_rows.push_back(stim_row_t'{frames(KIND_EDGE, 16'h0000, 16'hFFFF, 16'h0000, 1'b0),
                                            1'b0, 16'h0000});
        directed_rows.push_back(stim_row_t'{frames(KIND_EDGE, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0),
                                            1'b0, 16'h0000});
        directed_rows.push_back(stim_row_t'{frames(KIND_UNUSED, 16'd10, 16'd200, 16'd30, 1'b1),
                                            1'b0, 16'h0000});
        directed_rows.push_back(stim_row_t'{frames(KIND_INTRA, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0),
                                            1'b0, 16'h0000});
        w = frames(KIND_LINE, 16'd100, 16'd300, 16'd120, 1'b0);
        w.row_three_away = '1;
        directed_rows.push_back(stim_row_t'{w, 1'b0, 16'h0000});
        w = frames(KIND_LINE, 16'h8000, 16'h7FFF, 16'h0001, 1'b0);
        w.row_minus4 = '1;
        w.row_plus4 = '1;
        directed_rows.push_back(stim_row_t'{w, 1'b0, 16'h0000});
        for (int k = 0; k < 8; k++)
            directed_rows.push_back(stim_row_t'{rand_window(2'(k)), 1'b0, 16'h0000});

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].pixel);

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain_pipe();
                case (phase)
                    1:
                    begin
                        clip = 16'hFFFF;
                        par = 1'b1;
                        sc = 1'b0;
                    end
                    2:
                    begin
                        clip = 16'h0000;
                        par = 1'b0;
                        sc = 1'b0;
                    end
                    3:
                    begin
                        clip = 16'd1023;
                        par = 1'b1;
                        sc = 1'b1;
                    end
                    4:
                    begin
                        clip = 16'd1;
                        par = 1'b0;
                        sc = 1'b1;
                    end
                    default:
                    begin
                        clip = 16'($urandom_range(0, 65535));
                        par = $urandom_range(0, 1);
                        sc = $urandom_range(0, 1);
                    end
                endcase
                program_regs(clip, par, sc);
            end
            repeat (RAND_PER_PHASE)
                send_beat(rand_window(2'($urandom_range(0, 3))), 1'b0, 16'h0000);
        end

        drain_pipe();
        if (pending_pixels.size() != 0)
        begin
            $display("%0d expected pixels never came out", pending_pixels.size());
            error_count += pending_pixels.size();
        end
        $display("checked %0d pixels over %0d register settings", pixels_checked, settings_used);
        $display("beats by kind: intra %0d, line %0d, edge %0d, unused %0d",
                 kind_count[KIND_INTRA], kind_count[KIND_LINE], kind_count[KIND_EDGE],
                 kind_count[KIND_UNUSED]);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
